[rtl/core/fcl_train_pkg.sv]
package fcl_train_pkg;

	// Defaults for the top-level parameters
	localparam int MaxInputsDef    = 64;
	localparam int MaxOutputsDef   = 32;
	localparam int HistoryDepthDef = 16;

	// Request codes (s_tuser)
	typedef enum logic [2:0] {
		REQ_WR_WEIGHT = 3'd0,
		REQ_WR_BIAS   = 3'd1,
		REQ_RD_WEIGHT = 3'd2,
		REQ_RD_BIAS   = 3'd3,
		REQ_FORWARD   = 3'd4,
		REQ_BACKWARD  = 3'd5,
		REQ_END_BATCH = 3'd6,
		REQ_BEGIN_SEQ = 3'd7
	} req_t;

	// Result kinds (m_tuser)
	typedef enum logic [1:0] {
		KIND_FORWARD   = 2'd0,
		KIND_INPUT_ERR = 2'd1,
		KIND_READ      = 2'd2,
		KIND_DONE      = 2'd3
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_HIST_FULL  = 2'd1,
		ST_HIST_EMPTY = 2'd2
	} status_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_INPUT_LENGTH  = 3'd0,
		CFG_OUTPUT_LENGTH = 3'd1,
		CFG_WEIGHT_STEP   = 3'd2,
		CFG_BIAS_STEP     = 3'd3,
		CFG_MOMENTUM_KEEP = 3'd4,
		CFG_BACKPROP_EN   = 3'd5
	} cfg_idx_t;

	// Wide signed intermediate for sums and products
	typedef logic signed [49:0] wide_t;

	function automatic logic signed [15:0] sat16(input wide_t v);
		if (v > 50'sd32767) begin
			return 16'sh7fff;
		end else if (v < -50'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input wide_t v);
		if (v > 50'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -50'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

[rtl/core/fcl_ram.sv]
module fcl_ram #(
	parameter int Depth = 32,
	parameter int Width = 16,
	localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [Aw-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic [Aw-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/fully_connected_layer_train_top.sv]
// Trainable fully connected layer, fixed point Q3.12 data, Q7.24 gradients.
// Slave stream: s_tuser carries the request code, s_tdata row, col and value.
// Master stream: m_tuser carries the result kind, m_tdata index, value and
// status, m_tlast marks the last word of a result run.
// Configuration: cfg_we with cfg_index/cfg_data writes one register per cycle.
// One request is worked at a time; s_tready is high only while idle.
// Forward element: read, multiply and write-back of the accumulator memory
// for each output in use; the closing element adds a result run over the
// outputs. Backward element: bias gradient update, then read, multiply and
// write-back for each input in use, plus the input error run on the last
// row when backprop is enabled. End of batch: read, multiply and write-back
// for each weight in use, then each bias, then one word. Begin sequence and
// the end of each result run or last backward row sweep the accumulators.
// After reset a clearing pass zeroes the gradient and accumulator
// memories; s_tready stays low during it.
// A stalled receiver holds the output register; the sequencer waits on it
// without losing words.
module fully_connected_layer_train_top
	import fcl_train_pkg::*;
#(
	parameter int MAX_INPUTS    = MaxInputsDef,
	parameter int MAX_OUTPUTS   = MaxOutputsDef,
	parameter int HISTORY_DEPTH = HistoryDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // row[4:0], col[10:5], value[26:11], zero pad
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // index[5:0], out_value[21:6], status[23:22]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int WN  = MAX_OUTPUTS * MAX_INPUTS;
	localparam int WAW = (WN > 1) ? $clog2(WN) : 1;
	localparam int HN  = HISTORY_DEPTH * MAX_INPUTS;
	localparam int HAW = (HN > 1) ? $clog2(HN) : 1;
	localparam int CW  = $clog2(HISTORY_DEPTH + 1);
	localparam int NIW = $clog2(MAX_INPUTS + 1);
	localparam int NOW = $clog2(MAX_OUTPUTS + 1);
	localparam int SW  = (MAX_OUTPUTS > MAX_INPUTS) ? MAX_OUTPUTS : MAX_INPUTS;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISP, S_RD_WAIT, S_ONE,
		S_FW_RD, S_FW_MUL, S_FW_WB, S_FO_RD, S_FO_EMIT,
		S_BB_RD, S_BB_WB, S_BW_RD, S_BW_MUL, S_BW_WB, S_BE_RD, S_BE_EMIT,
		S_EB_RD, S_EB_MUL, S_EB_WB, S_EBB_RD, S_EBB_MUL, S_EBB_WB, S_CLR
	} state_t;

	// Configuration registers
	logic [6:0]  in_len_q;
	logic [5:0]  out_len_q;
	logic [15:0] wstep_q, bstep_q, keep_q;
	logic        bp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_len_q  <= 7'd64;
			out_len_q <= 6'd32;
			wstep_q   <= '0;
			bstep_q   <= '0;
			keep_q    <= '0;
			bp_q      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INPUT_LENGTH:  in_len_q  <= cfg_data[6:0];
				CFG_OUTPUT_LENGTH: out_len_q <= cfg_data[5:0];
				CFG_WEIGHT_STEP:   wstep_q   <= cfg_data;
				CFG_BIAS_STEP:     bstep_q   <= cfg_data;
				CFG_MOMENTUM_KEEP: keep_q    <= cfg_data;
				CFG_BACKPROP_EN:   bp_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Lengths in use, clamped to 1..max
	logic [NIW-1:0] nin;
	logic [NOW-1:0] nout;
	always_comb begin
		if (in_len_q == '0) begin
			nin = NIW'(1);
		end else if (32'(in_len_q) > MAX_INPUTS) begin
			nin = NIW'(MAX_INPUTS);
		end else begin
			nin = NIW'(in_len_q);
		end
		if (out_len_q == '0) begin
			nout = NOW'(1);
		end else if (32'(out_len_q) > MAX_OUTPUTS) begin
			nout = NOW'(MAX_OUTPUTS);
		end else begin
			nout = NOW'(out_len_q);
		end
	end

	state_t state_q;
	req_t   req_q;
	logic [4:0]  row_q;
	logic [5:0]  col_q;
	logic signed [15:0] x_q;
	logic [OW-1:0]  j_q;
	logic [IW-1:0]  k_q;
	logic [WAW-1:0] c_q;
	logic [CW-1:0]  hc_q;
	logic           clr_o_q, clr_i_q;
	wide_t          prod_a_s1, prod_b_s1;
	logic [1:0]  res_kind_q, res_st_q;
	logic [5:0]  res_idx_q;
	logic [15:0] res_val_q;
	logic        ov_q, o_last_q;
	logic [1:0]  o_kind_q, o_st_q;
	logic [5:0]  o_idx_q;
	logic [15:0] o_val_q;

	// Memory ports
	logic           w_we, g_we, b_we, bg_we, oa_we, h_we, ia_we;
	logic [WAW-1:0] w_wa, w_ra, g_wa, g_ra;
	logic [OW-1:0]  b_wa, b_ra, bg_wa, bg_ra, oa_wa, oa_ra;
	logic [HAW-1:0] h_wa, h_ra;
	logic [IW-1:0]  ia_wa, ia_ra;
	logic [15:0]    w_wd, w_rd, b_wd, b_rd, h_rd;
	logic [31:0]    g_wd, g_rd, bg_wd, bg_rd, oa_wd, oa_rd, ia_wd, ia_rd;

	fcl_ram #(.Depth(WN), .Width(16)) u_weight (
		.clk, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
	fcl_ram #(.Depth(WN), .Width(32)) u_wgrad (
		.clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
	fcl_ram #(.Depth(MAX_OUTPUTS), .Width(16)) u_bias (
		.clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
	fcl_ram #(.Depth(MAX_OUTPUTS), .Width(32)) u_bgrad (
		.clk, .we(bg_we), .waddr(bg_wa), .wdata(bg_wd), .raddr(bg_ra), .rdata(bg_rd));
	fcl_ram #(.Depth(MAX_OUTPUTS), .Width(32)) u_oacc (
		.clk, .we(oa_we), .waddr(oa_wa), .wdata(oa_wd), .raddr(oa_ra), .rdata(oa_rd));
	fcl_ram #(.Depth(HN), .Width(16)) u_hist (
		.clk, .we(h_we), .waddr(h_wa), .wdata(x_q), .raddr(h_ra), .rdata(h_rd));
	fcl_ram #(.Depth(MAX_INPUTS), .Width(32)) u_iacc (
		.clk, .we(ia_we), .waddr(ia_wa), .wdata(ia_wd), .raddr(ia_ra), .rdata(ia_rd));

	// Addresses and range checks
	logic [WAW-1:0] wa_rc, wa_jc, wa_rk, wa_jk;
	logic row_in_w, row_in_o, col_in_w, col_in_n, row_in_n, hist_full;
	logic j_last, k_last, c_in_o, c_in_i;
	assign wa_rc = WAW'(32'(row_q) * MAX_INPUTS + 32'(col_q));
	assign wa_jc = WAW'(32'(j_q) * MAX_INPUTS + 32'(col_q));
	assign wa_rk = WAW'(32'(row_q) * MAX_INPUTS + 32'(k_q));
	assign wa_jk = WAW'(32'(j_q) * MAX_INPUTS + 32'(k_q));
	assign row_in_o  = 32'(row_q) < MAX_OUTPUTS;
	assign col_in_w  = 32'(col_q) < MAX_INPUTS;
	assign row_in_w  = row_in_o && col_in_w;
	assign col_in_n  = 32'(col_q) < 32'(nin);
	assign row_in_n  = 32'(row_q) < 32'(nout);
	assign hist_full = 32'(hc_q) >= HISTORY_DEPTH;
	assign j_last    = 32'(j_q) == 32'(nout) - 32'd1;
	assign k_last    = 32'(k_q) == 32'(nin) - 32'd1;
	assign c_in_o    = 32'(c_q) < MAX_OUTPUTS;
	assign c_in_i    = 32'(c_q) < MAX_INPUTS;

	// Arithmetic
	logic signed [31:0] ma_l, mb_l;
	logic signed [16:0] ma_r, mb_r;
	logic signed [48:0] ma_p, mb_p;
	logic signed [15:0] fo_val, be_val, upd16;
	logic signed [31:0] fw_sum, bb_sum, bw_g, bw_i, keep32;
	wide_t              step_d;

	always_comb begin
		ma_l = 32'(signed'(h_rd));
		mb_l = 32'(signed'(w_rd));
		ma_r = 17'(x_q);
		mb_r = 17'(x_q);
		case (state_q)
			S_FW_MUL: ma_l = 32'(signed'(w_rd));
			S_EB_MUL: begin
				ma_l = signed'(g_rd);
				mb_l = signed'(g_rd);
				ma_r = signed'({1'b0, wstep_q});
				mb_r = signed'({1'b0, keep_q});
			end
			S_EBB_MUL: begin
				ma_l = signed'(bg_rd);
				mb_l = signed'(bg_rd);
				ma_r = signed'({1'b0, bstep_q});
				mb_r = signed'({1'b0, keep_q});
			end
			default: ;
		endcase
	end
	assign ma_p = ma_l * ma_r;
	assign mb_p = mb_l * mb_r;

	assign fw_sum = sat32(wide_t'(signed'(oa_rd)) + prod_a_s1);
	assign fo_val = sat16(((wide_t'(signed'(b_rd)) <<< 12) + wide_t'(signed'(oa_rd))
		+ 50'sd2048) >>> 12);
	assign bb_sum = sat32(wide_t'(signed'(bg_rd)) + (wide_t'(x_q) <<< 12));
	assign bw_g   = sat32(wide_t'(signed'(g_rd)) + prod_a_s1);
	assign bw_i   = sat32(wide_t'(signed'(ia_rd)) + prod_b_s1);
	assign be_val = sat16((wide_t'(signed'(ia_rd)) + 50'sd2048) >>> 12);
	assign step_d = (prod_a_s1 + 50'sd134217728) >>> 28;
	assign keep32 = sat32((prod_b_s1 + 50'sd32768) >>> 16);
	assign upd16  = sat16(((state_q == S_EBB_WB) ? wide_t'(signed'(b_rd))
		: wide_t'(signed'(w_rd))) + step_d);

	// Memory control
	always_comb begin
		w_we  = 1'b0;
		w_wa  = wa_rc;
		w_wd  = x_q;
		w_ra  = wa_jk;
		g_we  = 1'b0;
		g_wa  = wa_jk;
		g_wd  = keep32;
		g_ra  = wa_jk;
		b_we  = 1'b0;
		b_wa  = OW'(row_q);
		b_wd  = x_q;
		b_ra  = j_q;
		bg_we = 1'b0;
		bg_wa = j_q;
		bg_wd = keep32;
		bg_ra = j_q;
		oa_we = 1'b0;
		oa_wa = j_q;
		oa_wd = fw_sum;
		oa_ra = j_q;
		h_we  = 1'b0;
		h_wa  = HAW'(32'(hc_q) * MAX_INPUTS + 32'(col_q));
		h_ra  = HAW'((32'(hc_q) - 32'd1) * MAX_INPUTS + 32'(k_q));
		ia_we = 1'b0;
		ia_wa = k_q;
		ia_wd = bw_i;
		ia_ra = k_q;
		case (state_q)
			S_INIT: begin
				g_we  = 1'b1;
				g_wa  = c_q;
				g_wd  = '0;
				bg_we = c_in_o;
				bg_wa = OW'(c_q);
				bg_wd = '0;
				oa_we = c_in_o;
				oa_wa = OW'(c_q);
				oa_wd = '0;
				ia_we = c_in_i;
				ia_wa = IW'(c_q);
				ia_wd = '0;
			end
			S_CLR: begin
				oa_we = clr_o_q && c_in_o;
				oa_wa = OW'(c_q);
				oa_wd = '0;
				ia_we = clr_i_q && c_in_i;
				ia_wa = IW'(c_q);
				ia_wd = '0;
			end
			S_DISP: begin
				w_ra  = wa_rc;
				b_ra  = OW'(row_q);
				w_we  = (req_q == REQ_WR_WEIGHT) && row_in_w;
				b_we  = (req_q == REQ_WR_BIAS) && row_in_o;
				h_we  = (req_q == REQ_FORWARD) && col_in_n && !hist_full;
			end
			S_FW_RD, S_FW_MUL: w_ra = wa_jc;
			S_FW_WB: oa_we = 1'b1;
			S_BB_RD: bg_ra = OW'(row_q);
			S_BB_WB: begin
				bg_we = 1'b1;
				bg_wa = OW'(row_q);
				bg_wd = bb_sum;
			end
			S_BW_RD, S_BW_MUL: begin
				w_ra = wa_rk;
				g_ra = wa_rk;
			end
			S_BW_WB: begin
				w_ra  = wa_rk;
				g_ra  = wa_rk;
				g_we  = 1'b1;
				g_wa  = wa_rk;
				g_wd  = bw_g;
				ia_we = bp_q;
			end
			S_EB_WB: begin
				w_we = 1'b1;
				w_wa = wa_jk;
				w_wd = upd16;
				g_we = 1'b1;
			end
			S_EBB_WB: begin
				b_we  = 1'b1;
				b_wa  = j_q;
				b_wd  = upd16;
				bg_we = 1'b1;
			end
			default: ;
		endcase
	end

	logic slot_free;
	assign slot_free = !ov_q || m_tready;

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			req_q      <= REQ_WR_WEIGHT;
			row_q      <= '0;
			col_q      <= '0;
			x_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			c_q        <= '0;
			hc_q       <= '0;
			clr_o_q    <= 1'b0;
			clr_i_q    <= 1'b0;
			prod_a_s1  <= '0;
			prod_b_s1  <= '0;
			res_kind_q <= '0;
			res_st_q   <= '0;
			res_idx_q  <= '0;
			res_val_q  <= '0;
			ov_q       <= 1'b0;
			o_last_q   <= 1'b0;
			o_kind_q   <= '0;
			o_st_q     <= '0;
			o_idx_q    <= '0;
			o_val_q    <= '0;
		end else begin
			if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					c_q <= c_q + 1'b1;
					if (32'(c_q) == WN - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						req_q   <= req_t'(s_tuser);
						row_q   <= s_tdata[4:0];
						col_q   <= s_tdata[10:5];
						x_q     <= signed'(s_tdata[26:11]);
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					j_q <= '0;
					k_q <= '0;
					c_q <= '0;
					res_st_q  <= ST_OK;
					res_val_q <= '0;
					case (req_q)
						REQ_WR_WEIGHT, REQ_WR_BIAS: state_q <= S_IDLE;
						REQ_RD_WEIGHT: begin
							res_kind_q <= KIND_READ;
							res_idx_q  <= col_q;
							state_q    <= row_in_w ? S_RD_WAIT : S_ONE;
						end
						REQ_RD_BIAS: begin
							res_kind_q <= KIND_READ;
							res_idx_q  <= {1'b0, row_q};
							state_q    <= row_in_o ? S_RD_WAIT : S_ONE;
						end
						REQ_FORWARD: begin
							res_kind_q <= KIND_FORWARD;
							res_idx_q  <= col_q;
							res_st_q   <= ST_HIST_FULL;
							if (!col_in_n) begin
								state_q <= S_IDLE;
							end else if (hist_full) begin
								state_q <= S_ONE;
							end else begin
								state_q <= S_FW_RD;
							end
						end
						REQ_BACKWARD: begin
							res_kind_q <= KIND_INPUT_ERR;
							res_idx_q  <= {1'b0, row_q};
							res_st_q   <= ST_HIST_EMPTY;
							if (!row_in_n) begin
								state_q <= S_IDLE;
							end else if (hc_q == '0) begin
								state_q <= S_ONE;
							end else begin
								state_q <= S_BB_RD;
							end
						end
						REQ_END_BATCH: state_q <= S_EB_RD;
						default: begin
							hc_q    <= '0;
							clr_o_q <= 1'b1;
							clr_i_q <= 1'b1;
							state_q <= S_CLR;
						end
					endcase
				end
				S_RD_WAIT: begin
					res_val_q <= (req_q == REQ_RD_WEIGHT) ? w_rd : b_rd;
					state_q   <= S_ONE;
				end
				S_ONE: begin
					if (slot_free) begin
						ov_q     <= 1'b1;
						o_kind_q <= res_kind_q;
						o_idx_q  <= res_idx_q;
						o_val_q  <= res_val_q;
						o_st_q   <= res_st_q;
						o_last_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				// Forward: accumulate w*x into each output
				S_FW_RD: state_q <= S_FW_MUL;
				S_FW_MUL: begin
					prod_a_s1 <= wide_t'(ma_p);
					state_q   <= S_FW_WB;
				end
				S_FW_WB: begin
					if (!j_last) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_FW_RD;
					end else if (k_last_col()) begin
						j_q     <= '0;
						state_q <= S_FO_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FO_RD: state_q <= S_FO_EMIT;
				S_FO_EMIT: begin
					if (slot_free) begin
						ov_q     <= 1'b1;
						o_kind_q <= KIND_FORWARD;
						o_idx_q  <= 6'(j_q);
						o_val_q  <= fo_val;
						o_st_q   <= ST_OK;
						o_last_q <= j_last;
						if (j_last) begin
							hc_q    <= hc_q + 1'b1;
							clr_o_q <= 1'b1;
							clr_i_q <= 1'b0;
							c_q     <= '0;
							state_q <= S_CLR;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_FO_RD;
						end
					end
				end
				// Backward: bias gradient, then weight gradient and input error
				S_BB_RD: state_q <= S_BB_WB;
				S_BB_WB: state_q <= S_BW_RD;
				S_BW_RD: state_q <= S_BW_MUL;
				S_BW_MUL: begin
					prod_a_s1 <= wide_t'(ma_p);
					prod_b_s1 <= wide_t'(mb_p);
					state_q   <= S_BW_WB;
				end
				S_BW_WB: begin
					if (!k_last) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_BW_RD;
					end else if (32'(row_q) == 32'(nout) - 32'd1) begin
						hc_q <= hc_q - 1'b1;
						k_q  <= '0;
						c_q  <= '0;
						if (bp_q) begin
							state_q <= S_BE_RD;
						end else begin
							clr_o_q <= 1'b0;
							clr_i_q <= 1'b1;
							state_q <= S_CLR;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_BE_RD: state_q <= S_BE_EMIT;
				S_BE_EMIT: begin
					if (slot_free) begin
						ov_q     <= 1'b1;
						o_kind_q <= KIND_INPUT_ERR;
						o_idx_q  <= 6'(k_q);
						o_val_q  <= be_val;
						o_st_q   <= ST_OK;
						o_last_q <= k_last;
						if (k_last) begin
							clr_o_q <= 1'b0;
							clr_i_q <= 1'b1;
							state_q <= S_CLR;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_BE_RD;
						end
					end
				end
				// End of batch: weights row by row, then biases
				S_EB_RD: state_q <= S_EB_MUL;
				S_EB_MUL: begin
					prod_a_s1 <= wide_t'(ma_p);
					prod_b_s1 <= wide_t'(mb_p);
					state_q   <= S_EB_WB;
				end
				S_EB_WB: begin
					state_q <= S_EB_RD;
					if (!k_last) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (j_last) begin
							j_q     <= '0;
							state_q <= S_EBB_RD;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				S_EBB_RD: state_q <= S_EBB_MUL;
				S_EBB_MUL: begin
					prod_a_s1 <= wide_t'(ma_p);
					prod_b_s1 <= wide_t'(mb_p);
					state_q   <= S_EBB_WB;
				end
				S_EBB_WB: begin
					if (j_last) begin
						res_kind_q <= KIND_DONE;
						res_idx_q  <= '0;
						res_st_q   <= ST_OK;
						state_q    <= S_ONE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_EBB_RD;
					end
				end
				S_CLR: begin
					c_q <= c_q + 1'b1;
					if (32'(c_q) == SW - 1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Forward element closes the vector
	function automatic logic k_last_col();
		return 32'(col_q) == 32'(nin) - 32'd1;
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = {o_st_q, o_val_q, o_idx_q};
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

	// History never grows past its depth
	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hc_q) <= HISTORY_DEPTH)
		else $error("history count beyond depth");

	// An error status always closes its run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (o_st_q != ST_OK) |-> m_tlast)
		else $error("error status without last");

	// A word left unaccepted is never overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word lost under stall");

	// No request taken while the clearing pass after reset runs
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> !s_tready)
		else $error("request accepted during clearing pass");

endmodule

[dv/fully_connected_layer_train_top_tb.sv]
`timescale 1ns / 100ps

module fully_connected_layer_train_top_tb;
	import fcl_train_pkg::*;

	localparam int NIN_MAX  = MaxInputsDef;
	localparam int NOUT_MAX = MaxOutputsDef;
	localparam int HIST_MAX = HistoryDepthDef;

	// One expected word on the result stream
	typedef struct {
		kind_t       kind;
		logic [5:0]  idx;
		logic [15:0] val;
		logic        last;
		status_t     st;
	} layer_word_t;

	// Layer predictor plus queue of words still owed by the block
	class layer_scoreboard;
		shortint     weights[NIN_MAX * NOUT_MAX];
		int          weight_grad[NIN_MAX * NOUT_MAX];
		shortint     biases[NOUT_MAX];
		int          bias_grad[NOUT_MAX];
		int          out_acc[NOUT_MAX];
		shortint     history[HIST_MAX * NIN_MAX];
		int          depth;
		int          in_err[NIN_MAX];
		int          in_len, out_len, w_step, b_step, keep, bp_on;
		layer_word_t owed[$];
		int          errors, words_seen;
		int          kind_count[4];

		function new();
			in_len = 64; out_len = 32; w_step = 0; b_step = 0; keep = 0; bp_on = 1;
			depth = 0; errors = 0; words_seen = 0;
			foreach (weights[i]) begin
				weights[i] = 0; weight_grad[i] = 0;
			end
			foreach (biases[i]) begin
				biases[i] = 0; bias_grad[i] = 0; out_acc[i] = 0;
			end
			foreach (history[i]) history[i] = 0;
			foreach (in_err[i]) in_err[i] = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function int clip32(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return int'(v);
		endfunction

		function shortint clip16(longint v);
			if (v > 32767) return 16'sh7fff;
			if (v < -32768) return 16'sh8000;
			return shortint'(v);
		endfunction

		// floor((v + half) / 2^sh)
		function longint round_shift(longint v, int sh);
			return (v + (longint'(1) << (sh - 1))) >>> sh;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] data);
			case (idx)
				CFG_INPUT_LENGTH:  in_len = data[6:0];
				CFG_OUTPUT_LENGTH: out_len = data[5:0];
				CFG_WEIGHT_STEP:   w_step = data;
				CFG_BIAS_STEP:     b_step = data;
				CFG_MOMENTUM_KEEP: keep = data;
				CFG_BACKPROP_EN:   bp_on = data[0];
				default: ;
			endcase
		endfunction

		function void owe(kind_t k, int idx, shortint v, bit last, status_t st);
			layer_word_t w;
			w.kind = k; w.idx = idx[5:0]; w.val = v; w.last = last; w.st = st;
			owed.push_back(w);
		endfunction

		function void note_request(req_t req, logic [4:0] row, logic [5:0] col,
				logic signed [15:0] value);
			int nin, nout, a, base;
			longint s;
			nin = (in_len < 1) ? 1 : (in_len > NIN_MAX ? NIN_MAX : in_len);
			nout = (out_len < 1) ? 1 : (out_len > NOUT_MAX ? NOUT_MAX : out_len);
			case (req)
				REQ_WR_WEIGHT: weights[row * NIN_MAX + col] = value;
				REQ_WR_BIAS:   biases[row] = value;
				REQ_RD_WEIGHT: owe(KIND_READ, col, weights[row * NIN_MAX + col], 1, ST_OK);
				REQ_RD_BIAS:   owe(KIND_READ, row, biases[row], 1, ST_OK);
				REQ_FORWARD: begin
					if (col < nin) begin
						if (depth >= HIST_MAX) begin
							owe(KIND_FORWARD, col, 0, 1, ST_HIST_FULL);
						end else begin
							history[depth * NIN_MAX + col] = value;
							for (int j = 0; j < nout; j++)
								out_acc[j] = clip32(longint'(out_acc[j]) +
									longint'(weights[j * NIN_MAX + col]) * value);
							if (col == nin - 1) begin
								for (int j = 0; j < nout; j++) begin
									s = longint'(biases[j]) * 4096 + out_acc[j];
									owe(KIND_FORWARD, j, clip16(round_shift(s, 12)),
										j == nout - 1, ST_OK);
								end
								foreach (out_acc[j]) out_acc[j] = 0;
								depth++;
							end
						end
					end
				end
				REQ_BACKWARD: begin
					if (row < nout) begin
						if (depth == 0) begin
							owe(KIND_INPUT_ERR, row, 0, 1, ST_HIST_EMPTY);
						end else begin
							base = (depth - 1) * NIN_MAX;
							bias_grad[row] = clip32(longint'(bias_grad[row]) +
								longint'(value) * 4096);
							for (int k = 0; k < nin; k++) begin
								a = row * NIN_MAX + k;
								weight_grad[a] = clip32(longint'(weight_grad[a]) +
									longint'(history[base + k]) * value);
								if (bp_on)
									in_err[k] = clip32(longint'(in_err[k]) +
										longint'(weights[a]) * value);
							end
							if (row == nout - 1) begin
								depth--;
								if (bp_on)
									for (int k = 0; k < nin; k++)
										owe(KIND_INPUT_ERR, k,
											clip16(round_shift(in_err[k], 12)),
											k == nin - 1, ST_OK);
								foreach (in_err[k]) in_err[k] = 0;
							end
						end
					end
				end
				REQ_END_BATCH: begin
					for (int j = 0; j < nout; j++) begin
						for (int k = 0; k < nin; k++) begin
							a = j * NIN_MAX + k;
							weights[a] = clip16(longint'(weights[a]) +
								round_shift(longint'(weight_grad[a]) * w_step, 28));
							weight_grad[a] = clip32(round_shift(longint'(weight_grad[a]) * keep, 16));
						end
						biases[j] = clip16(longint'(biases[j]) +
							round_shift(longint'(bias_grad[j]) * b_step, 28));
						bias_grad[j] = clip32(round_shift(longint'(bias_grad[j]) * keep, 16));
					end
					owe(KIND_DONE, 0, 0, 1, ST_OK);
				end
				default: begin
					depth = 0;
					foreach (out_acc[j]) out_acc[j] = 0;
					foreach (in_err[k]) in_err[k] = 0;
				end
			endcase
		endfunction

		function void check_word(logic [1:0] kind, logic [23:0] data, logic last);
			layer_word_t w;
			words_seen++;
			kind_count[kind]++;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected word kind=%0d data=%h last=%b",
						$realtime, kind, data, last);
				return;
			end
			w = owed.pop_front();
			if (kind !== w.kind || data[5:0] !== w.idx || data[21:6] !== w.val ||
					last !== w.last || data[23:22] !== w.st) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp kind=%0d idx=%0d val=%h last=%b st=%0d, got kind=%0d idx=%0d val=%h last=%b st=%0d",
						$realtime, w.kind, w.idx, w.val, w.last, w.st,
						kind, data[5:0], data[21:6], last, data[23:22]);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	layer_scoreboard sb;
	bit          gaps_on;
	int          words_in;
	int          n_in, n_out;

	fully_connected_layer_train_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stall bursts, checked on every accepted word
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tuser, m_tdata, m_tlast);
	end

	// Drive one request word; called at a falling edge, returns at one
	task automatic send(req_t req, int row, int col, logic [15:0] value);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {5'b0, value, col[5:0], row[4:0]};
		do @(posedge clk); while (!s_tready);
		sb.note_request(req, row[4:0], col[5:0], value);
		words_in++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Register write; block must be idle
	task automatic set_reg(cfg_idx_t idx, int data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data[15:0]);
		n_in = (sb.in_len < 1) ? 1 : (sb.in_len > NIN_MAX ? NIN_MAX : sb.in_len);
		n_out = (sb.out_len < 1) ? 1 : (sb.out_len > NOUT_MAX ? NOUT_MAX : sb.out_len);
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 8191)) - 16'd4096;
			default: return 16'($urandom);
		endcase
	endfunction

	// Full forward vector, last col closes it
	task automatic push_vector();
		int order[$];
		int t;
		for (int c = 0; c < n_in - 1; c++) order.push_back(c);
		order.shuffle();
		foreach (order[i]) send(REQ_FORWARD, $urandom_range(0, 31), order[i], rand_value());
		send(REQ_FORWARD, $urandom_range(0, 31), n_in - 1, rand_value());
	endtask

	task automatic error_vector();
		for (int r = 0; r < n_out; r++) begin
			if (n_out < NOUT_MAX && $urandom_range(0, 7) == 0)
				send(REQ_BACKWARD, $urandom_range(n_out, 31), 0, rand_value());
			send(REQ_BACKWARD, r, $urandom_range(0, 63), rand_value());
		end
	endtask

	task automatic random_run(int n_items);
		int start, pick;
		start = words_in;
		while (words_in - start < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				push_vector();
			end else if (pick < 60) begin
				error_vector();
			end else if (pick < 68) begin
				send(REQ_END_BATCH, $urandom_range(0, 31), $urandom_range(0, 63), rand_value());
			end else if (pick < 78) begin
				send(REQ_RD_WEIGHT, $urandom_range(0, 31), $urandom_range(0, 63), rand_value());
			end else if (pick < 84) begin
				send(REQ_RD_BIAS, $urandom_range(0, 31), $urandom_range(0, 63), rand_value());
			end else if (pick < 90) begin
				send(REQ_WR_WEIGHT, $urandom_range(0, 31), $urandom_range(0, 63), rand_value());
			end else if (pick < 93) begin
				send(REQ_WR_BIAS, $urandom_range(0, 31), $urandom_range(0, 63), rand_value());
			end else if (pick < 96) begin
				send(REQ_BEGIN_SEQ, $urandom_range(0, 31), $urandom_range(0, 63), rand_value());
			end else begin
				// noise: any request with any fields
				send(req_t'($urandom_range(0, 7)), $urandom_range(0, 31),
					$urandom_range(0, 63), rand_value());
			end
		end
	endtask

	initial begin
		int lens_in[6]  = '{2, 0, 127, 5, 1, 3};
		int lens_out[6] = '{3, 1, 0, 63, 2, 4};
		sb = new();
		words_in = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = REQ_WR_WEIGHT;
		cfg_we = 1'b0; cfg_index = CFG_INPUT_LENGTH; cfg_data = '0;
		n_in = 64; n_out = 32;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Load every weight and bias, then fill every history slot so no
		// later access touches an unwritten entry
		set_reg(CFG_INPUT_LENGTH, 64);
		set_reg(CFG_OUTPUT_LENGTH, 1);
		set_reg(CFG_WEIGHT_STEP, 16'h0400);
		set_reg(CFG_BIAS_STEP, 16'h1000);
		set_reg(CFG_MOMENTUM_KEEP, 16'h8000);
		set_reg(CFG_BACKPROP_EN, 1);
		for (int r = 0; r < NOUT_MAX; r++) begin
			for (int c = 0; c < NIN_MAX; c++)
				send(REQ_WR_WEIGHT, r, c, rand_value());
			send(REQ_WR_BIAS, r, 0, rand_value());
		end
		for (int v = 0; v < HIST_MAX; v++)
			for (int c = 0; c < NIN_MAX; c++)
				send(REQ_FORWARD, 0, c, rand_value());
		// stack full
		send(REQ_FORWARD, 0, 7, 16'h1234);
		send(REQ_BEGIN_SEQ, 0, 0, 16'h0000);
		drain();

		// Directed corner cases
		set_reg(CFG_INPUT_LENGTH, 4);
		set_reg(CFG_OUTPUT_LENGTH, 3);
		n_in = 4; n_out = 3;
		send(REQ_RD_WEIGHT, 0, 0, 16'h0000);
		send(REQ_RD_WEIGHT, 31, 63, 16'hffff);
		send(REQ_RD_BIAS, 0, 63, 16'h0000);
		send(REQ_RD_BIAS, 31, 0, 16'h0000);
		send(REQ_BACKWARD, 1, 0, 16'h1000);   // stack empty
		send(REQ_FORWARD, 0, 10, 16'h7fff);   // col out of use
		send(REQ_WR_WEIGHT, 2, 3, 16'h7fff);
		send(REQ_WR_BIAS, 2, 0, 16'h8000);
		send(REQ_FORWARD, 31, 0, 16'h7fff);
		send(REQ_FORWARD, 0, 1, 16'h8000);
		send(REQ_FORWARD, 5, 2, 16'h0000);
		send(REQ_FORWARD, 0, 3, 16'h7fff);
		send(REQ_BACKWARD, 9, 0, 16'h7fff);   // row out of use
		send(REQ_BACKWARD, 0, 0, 16'h7fff);
		send(REQ_BACKWARD, 1, 0, 16'h8000);
		send(REQ_BACKWARD, 2, 63, 16'h0001);
		send(REQ_END_BATCH, 0, 0, 16'h0000);
		send(REQ_RD_WEIGHT, 2, 3, 16'h0000);
		send(REQ_FORWARD, 0, 0, 16'h1000);
		send(REQ_BEGIN_SEQ, 31, 63, 16'hffff); // drops partial vector
		send(REQ_RD_BIAS, 2, 0, 16'h0000);
		drain();

		// Random phases across register settings
		for (int p = 0; p < 6; p++) begin
			set_reg(CFG_INPUT_LENGTH, lens_in[p]);
			set_reg(CFG_OUTPUT_LENGTH, lens_out[p]);
			set_reg(CFG_WEIGHT_STEP, (p == 1) ? 16'hffff : (p == 2 ? 0 : $urandom_range(0, 65535)));
			set_reg(CFG_BIAS_STEP, (p == 3) ? 16'hffff : (p == 4 ? 0 : $urandom_range(0, 65535)));
			set_reg(CFG_MOMENTUM_KEEP, (p == 2) ? 16'hffff : (p == 5 ? 0 : $urandom_range(0, 65535)));
			set_reg(CFG_BACKPROP_EN, (p == 3) ? 0 : $urandom_range(0, 1));
			if (p == 5) gaps_on = 1'b0;
			random_run((lens_in[p] == 127 || lens_out[p] == 63) ? 10 : 25);
			drain();
		end

		$display("Sent %0d requests across 6 register settings; checked %0d words", words_in,
			sb.words_seen);
		$display("Words by kind: fwd %0d, in-err %0d, read %0d, done %0d",
			sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3]);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d words missing", sb.errors, sb.owed.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
